// ===== sv/deque_pkg.sv =====
`default_nettype none

package deque_pkg;

  // Default sizes of the store.
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned ValueWidthDef = 64;

  // Fixed widths of the channel fields.
  localparam int unsigned CmdW    = 3;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // Command codes. Unlisted codes behave as a size query.
  typedef enum logic [CmdW-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_HEAD = 3'd2,
    CMD_REVERSE  = 3'd3,
    CMD_SIZE     = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input payload
    logic exec;     // apply the command to the store
  } dp_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/deque_ctrl.sv =====
`default_nettype none

module deque_ctrl
  import deque_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output dp_ctrl_t      ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Sequence one command: capture, execute, then hold the result.
  always_comb begin
    state_d        = state_q;
    ctrl_o.capture = 1'b0;
    ctrl_o.exec    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

`default_nettype wire

// ===== sv/deque_dpath.sv =====
`default_nettype none

module deque_dpath
  import deque_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_ctrl_t           ctrl_i,
  input  wire logic [CmdW-1:0]    command_i,
  input  wire logic [ValueW-1:0]  item_value_i,
  output logic [ValueW-1:0]       removed_value_o,
  output logic [StatusW-1:0]      status_o,
  output logic [CountW-1:0]       entry_count_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(QUEUE_DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(QUEUE_DEPTH);

  logic [VALUE_WIDTH-1:0] mem [QUEUE_DEPTH];

  logic [CmdW-1:0]        cmd_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [VALUE_WIDTH-1:0] rd_q;
  logic [IdxW-1:0]        front_q, front_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   rev_q, rev_d;
  logic [StatusW-1:0]     status_q, status_d;
  logic                   rem_ok_q, rem_ok_d;

  logic                   full, empty, is_ins, push_low, do_write;
  logic [IdxW-1:0]        front_dec, front_inc, high_slot, last_slot;
  logic [IdxW-1:0]        wr_addr, rd_addr;
  logic [SumW-1:0]        high_sum, last_sum;
  logic [CntW+CountW-1:0] count_ext;

  // Latch the payload of an accepted transfer.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= command_i;
      val_q <= item_value_i[VALUE_WIDTH-1:0];
    end
  end

  // Ring index arithmetic; sums stay below twice the depth.
  assign full      = (count_q == FullCnt);
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? LastIdx : front_q - IdxW'(1);
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + IdxW'(1);
  assign high_sum  = SumW'(front_q) + SumW'(count_q);
  assign last_sum  = high_sum - SumW'(1);
  assign high_slot = (high_sum >= DepthSum) ? IdxW'(high_sum - DepthSum) : IdxW'(high_sum);
  assign last_slot = (last_sum >= DepthSum) ? IdxW'(last_sum - DepthSum) : IdxW'(last_sum);

  assign is_ins   = (cmd_q == CMD_INS_HEAD) || (cmd_q == CMD_INS_TAIL);
  assign push_low = (cmd_q == CMD_INS_HEAD) != rev_q;
  assign do_write = ctrl_i.exec && is_ins && !full;
  assign wr_addr  = push_low ? front_dec : high_slot;
  assign rd_addr  = rev_q ? last_slot : front_q;

  // Next state of the ring for the held command.
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    rev_d    = rev_q;
    status_d = STAT_OK;
    rem_ok_d = 1'b0;
    case (cmd_q)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          count_d = count_q + CntW'(1);
          if (push_low) begin
            front_d = front_dec;
          end
        end
      end
      CMD_REM_HEAD: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          rem_ok_d = 1'b1;
          count_d  = count_q - CntW'(1);
          if (!rev_q) begin
            front_d = front_inc;
          end
        end
      end
      CMD_REVERSE: begin
        if (count_q >= CntW'(2)) begin
          rev_d = !rev_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Ring control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
    end else if (ctrl_i.exec) begin
      front_q <= front_d;
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      status_q <= status_d;
      rem_ok_q <= rem_ok_d;
    end
  end

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[wr_addr] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign count_ext       = (CntW + CountW)'(count_q);
  assign removed_value_o = rem_ok_q ? ValueW'(rd_q) : '0;
  assign status_o        = status_q;
  assign entry_count_o   = count_ext[CountW-1:0];

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_with_reverse_unit.sv =====
// Bounded double-ended queue held as a ring buffer with an orientation flag.
// A command passes through the states idle (capture), execute and output; its result
// is held until taken, and no new command is accepted before then. The payload is
// latched on acceptance and applied in the execute state.
// Reset clears the ring pointers, count, orientation and control; the entry
// store keeps its contents and needs no clearing pass.
`default_nettype none

module double_ended_queue_with_reverse_unit
  import deque_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CmdW-1:0]    command_i,
  input  wire logic [ValueW-1:0]  item_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [ValueW-1:0]       removed_value_o,
  output logic [StatusW-1:0]      status_o,
  output logic [CountW-1:0]       entry_count_o
);

  dp_ctrl_t ctrl;

  // Command sequencer.
  deque_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  // Ring buffer datapath.
  deque_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .command_i       (command_i),
    .item_value_i    (item_value_i),
    .removed_value_o (removed_value_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o)
  );

  // A waiting result blocks new input.
  a_out_blocks_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result waits");

  // An input transfer is followed by the execute cycle, then the result.
  a_in_then_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && !out_valid_o) ##1 out_valid_o)
    else $error("result not presented after execute");

  // An output transfer returns the block to idle.
  a_out_then_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o)
    else $error("not idle after output transfer");

  // Only a successful remove returns a value.
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> (removed_value_o == '0))
    else $error("value returned with failing status");

endmodule

`default_nettype wire

// ===== dv/deque_checker.sv =====
`timescale 1ns / 1ps

module deque_checker
  import deque_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [CmdW-1:0]    command_i,
  input  logic [ValueW-1:0]  item_value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [ValueW-1:0]  removed_value_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [CountW-1:0]  entry_count_i,
  output int                 fail_cnt_o,
  output int                 pending_cnt_o,
  output int                 checked_cnt_o,
  output int                 full_cnt_o,
  output int                 empty_cnt_o
);

  localparam int unsigned Depth = QueueDepthDef;
  localparam logic [ValueW-1:0] ValMask = {ValueW{1'b1}} >> (ValueW - ValueWidthDef);

  // One result of the queue as the block should report it.
  typedef struct packed {
    logic [ValueW-1:0] removed;
    status_e           status;
    logic [CountW-1:0] count;
  } deque_result_t;

  // Shadow copy of the ring buffer.
  logic [ValueW-1:0] shadow_mem [Depth];
  int unsigned       front_idx;
  int unsigned       held_cnt;
  logic              reversed;

  deque_result_t expected_q[$];

  // Print one line for a mismatch and count it.
  task automatic report_mismatch(input string what, input logic [ValueW-1:0] got,
                                 input logic [ValueW-1:0] want);
    $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
             checked_cnt_o, what, got, want);
    fail_cnt_o++;
  endtask

  // Apply one command to the shadow queue and work out its result.
  task automatic apply_command(input logic [CmdW-1:0] op, input logic [ValueW-1:0] value,
                               output deque_result_t res);
    logic        at_head;
    int unsigned slot;
    res.removed = '0;
    res.status  = STAT_OK;
    case (op)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (held_cnt >= Depth) begin
          res.status = STAT_FULL;
        end else begin
          at_head = (op == CMD_INS_HEAD);
          // The logical head sits at the low end unless the queue is reversed.
          if (at_head != reversed) begin
            front_idx = (front_idx + Depth - 1) % Depth;
            shadow_mem[front_idx] = value & ValMask;
          end else begin
            slot = (front_idx + held_cnt) % Depth;
            shadow_mem[slot] = value & ValMask;
          end
          held_cnt++;
        end
      end
      CMD_REM_HEAD: begin
        if (held_cnt == 0) begin
          res.status = STAT_EMPTY;
        end else if (!reversed) begin
          res.removed = shadow_mem[front_idx];
          front_idx = (front_idx + 1) % Depth;
          held_cnt--;
        end else begin
          slot = (front_idx + held_cnt - 1) % Depth;
          res.removed = shadow_mem[slot];
          held_cnt--;
        end
      end
      CMD_REVERSE: begin
        if (held_cnt >= 2) reversed = !reversed;
      end
      // Size query and the unused codes change nothing.
      default: ;
    endcase
    res.removed = res.removed & ValMask;
    res.count   = CountW'(held_cnt);
  endtask

  // Compare each result transfer, then predict for each command transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    deque_result_t got_pred;
    if (!rst_ni) begin
      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      front_idx     = 0;
      held_cnt      = 0;
      reversed      = 1'b0;
      expected_q.delete();
      fail_cnt_o    = 0;
      pending_cnt_o = 0;
      checked_cnt_o = 0;
      full_cnt_o    = 0;
      empty_cnt_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no command waiting", removed_value_i, '0);
        end else begin
          want = expected_q.pop_front();
          if (removed_value_i !== want.removed) begin
            report_mismatch("removed_value", removed_value_i, want.removed);
          end
          if (status_i !== want.status) begin
            report_mismatch("status", ValueW'(status_i), ValueW'(want.status));
          end
          if (entry_count_i !== want.count) begin
            report_mismatch("entry_count", ValueW'(entry_count_i), ValueW'(want.count));
          end
          if (want.status == STAT_FULL) full_cnt_o++;
          if (want.status == STAT_EMPTY) empty_cnt_o++;
          checked_cnt_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_command(command_i, item_value_i, got_pred);
        expected_q.push_back(got_pred);
      end
      pending_cnt_o = expected_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import deque_pkg::*;

  localparam int unsigned RandomItems = 1700;
  localparam int unsigned BlockLen    = 50;
  localparam int unsigned CalmFirst   = 700;
  localparam int unsigned CalmLast    = 1000;
  localparam int unsigned QuietLimit  = 2000;
  localparam logic [CmdW-1:0] CmdUnusedLo = 3'd5;
  localparam logic [CmdW-1:0] CmdUnusedHi = 3'd7;

  // Command mix of one block of random traffic.
  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } mix_mode_e;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [CmdW-1:0]    command_i    = CMD_SIZE;
  logic [ValueW-1:0]  item_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [ValueW-1:0]  removed_value_o;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0]  entry_count_o;

  int   fail_cnt;
  int   pending_cnt;
  int   checked_cnt;
  int   full_cnt;
  int   empty_cnt;
  logic calm       = 1'b0;
  int   sent_cnt   = 0;
  int   quiet_cnt  = 0;

  double_ended_queue_with_reverse_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

  deque_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .item_value_i   (item_value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .removed_value_i(removed_value_o),
    .status_i       (status_o),
    .entry_count_i  (entry_count_o),
    .fail_cnt_o     (fail_cnt),
    .pending_cnt_o  (pending_cnt),
    .checked_cnt_o  (checked_cnt),
    .full_cnt_o     (full_cnt),
    .empty_cnt_o    (empty_cnt)
  );

  // Clock, 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The result side stalls now and then, except in the calm stretch.
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 8);
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QuietLimit) begin
      $display("Timeout: no transfer for %0d cycles", QuietLimit);
      $display("double_ended_queue_with_reverse_unit verification failed");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // Present one command and hold it until the block takes it.
  task automatic send_command(input logic [CmdW-1:0] op, input logic [ValueW-1:0] value);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= op;
    item_value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Value handle: mostly random, sometimes all zeros or all ones.
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Command drawn from the mix of the current block.
  function automatic logic [CmdW-1:0] pick_command(input mix_mode_e mode);
    int unsigned roll;
    int unsigned ins_pct;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  ins_pct = 65;
      MODE_DRAIN: ins_pct = 20;
      default:    ins_pct = 43;
    endcase
    if (roll < ins_pct) return ($urandom_range(0, 1) == 1) ? CMD_INS_TAIL : CMD_INS_HEAD;
    if (roll < 85) return CMD_REM_HEAD;
    if (roll < 93) return CMD_REVERSE;
    if (roll < 97) return CMD_SIZE;
    return CmdW'(CmdUnusedLo + $urandom_range(0, CmdUnusedHi - CmdUnusedLo));
  endfunction

  initial begin : stimulus
    mix_mode_e mode;
    mode = MODE_MIXED;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty queue, single entry, fill to full, overflow at both ends.
    send_command(CMD_SIZE, '1);
    send_command(CMD_REM_HEAD, '1);
    send_command(CMD_REVERSE, '0);
    send_command(CMD_INS_HEAD, '1);
    send_command(CMD_REVERSE, '0);
    for (int i = 0; i < 15; i++) begin
      send_command((i % 2 == 1) ? CMD_INS_TAIL : CMD_INS_HEAD,
                   (i == 0) ? '0 : {$urandom, $urandom});
    end
    send_command(CMD_INS_HEAD, {$urandom, $urandom});
    send_command(CMD_INS_TAIL, {$urandom, $urandom});
    send_command(CmdUnusedLo, '1);
    send_command(CmdW'(CmdUnusedLo + 1), '0);
    send_command(CmdUnusedHi, {$urandom, $urandom});

    // Random traffic in blocks that lean toward filling, draining or neither.
    for (int n = 0; n < RandomItems; n++) begin
      if (n % BlockLen == 0) mode = mix_mode_e'($urandom_range(0, 2));
      calm <= (n >= CalmFirst && n < CalmLast);
      send_command(pick_command(mode), pick_value());
    end
    in_valid_i <= 1'b0;
    calm       <= 1'b0;

    // Drain the remaining results, then wait for any stray results.
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);

    $display("Sent %0d commands, all eight command codes, with stalls on both channels.",
             sent_cnt);
    $display("Compared %0d results: %0d inserts into a full queue, %0d removes when empty.",
             checked_cnt, full_cnt, empty_cnt);
    if (fail_cnt == 0) begin
      $display("double_ended_queue_with_reverse_unit verification clean");
    end else begin
      $display("double_ended_queue_with_reverse_unit verification failed");
    end
    $finish;
  end

endmodule
